// File: hw/rtl/qsu_pkg.sv
// Shared types, character codes and helpers for the quoted string unescaper.
package qsu_pkg;

    localparam int QueueDepth = 8;
    localparam int MaxResults = 4;

    typedef enum logic [3:0] {
        MODE_OPEN,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX,
        MODE_USTART,
        MODE_U4,
        MODE_UBRACE,
        MODE_DRAIN
    } mode_t;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_WRAPPER,
        ERR_ESCAPE,
        ERR_HEX,
        ERR_UNICODE,
        ERR_UNTERMINATED,
        ERR_TOO_LARGE,
        ERR_SURROGATE
    } err_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       done;
        err_t       err;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    localparam logic [23:0] CpMax    = 24'h10FFFF;
    localparam logic [23:0] SurrMask = 24'hFFF800;
    localparam logic [23:0] SurrBase = 24'h00D800;

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChHash   = 8'h23;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChA      = 8'h61;
    localparam logic [7:0] ChB      = 8'h62;
    localparam logic [7:0] ChE      = 8'h65;
    localparam logic [7:0] ChF      = 8'h66;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChU      = 8'h75;
    localparam logic [7:0] ChV      = 8'h76;
    localparam logic [7:0] ChX      = 8'h78;
    localparam logic [7:0] ChLbrace = 8'h7B;
    localparam logic [7:0] ChRbrace = 8'h7D;

    localparam logic [7:0] CtlBel = 8'd7;
    localparam logic [7:0] CtlBs  = 8'd8;
    localparam logic [7:0] CtlTab = 8'd9;
    localparam logic [7:0] CtlLf  = 8'd10;
    localparam logic [7:0] CtlVt  = 8'd11;
    localparam logic [7:0] CtlFf  = 8'd12;
    localparam logic [7:0] CtlCr  = 8'd13;
    localparam logic [7:0] CtlEsc = 8'd27;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            h.val = b[3:0];
        end
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.val = b[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic result_t make_result(input logic [7:0] data, input logic has,
                                            input logic done, input err_t err);
        result_t r;
        r.data = data;
        r.has  = has;
        r.done = done;
        r.err  = err;
        return r;
    endfunction

endpackage

// File: hw/rtl/quoted_string_unescaper_unit.sv
// Quoted string unescaper: decodes a dumped double-quoted string into body bytes.
//
// One byte of the dumped string is taken per beat, every cycle, and decoded in
// the cycle it is accepted; its results (none to four, escapes with UTF-8 code
// points give the most) go into an 8-entry result queue that drains one result
// per output beat. The input stalls only while more than four results are
// queued, so the input rate is one byte per cycle as long as the output keeps
// up on average; the single-port drain of the result queue sets the limit.
// After an error result, bytes are dropped until the next marked last byte.
module quoted_string_unescaper_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       done_res,
    output logic [2:0] error_code
);

    localparam int PtrW = $clog2(qsu_pkg::QueueDepth);

    qsu_pkg::mode_t   mode_reg, mode_next;
    logic [23:0]      acc_reg, acc_next;
    logic [2:0]       cnt_reg, cnt_next;

    qsu_pkg::result_t queue_reg [qsu_pkg::QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]    fill_reg, fill_next;

    qsu_pkg::result_t res [qsu_pkg::MaxResults];
    logic [2:0]       nres;
    logic             do_fail, do_emit;
    qsu_pkg::err_t    fail_err;
    logic [23:0]      cp;
    qsu_pkg::hex_t    hx;
    logic             push, pop;

    assign in_stall  = fill_reg > (PtrW+1)'(qsu_pkg::QueueDepth - qsu_pkg::MaxResults);
    assign push      = in_valid && !in_stall;
    assign out_valid = fill_reg != '0;
    assign pop       = out_valid && !out_stall;

    assign out_byte   = queue_reg[rd_ptr_reg].data;
    assign has_byte   = queue_reg[rd_ptr_reg].has;
    assign done_res   = queue_reg[rd_ptr_reg].done;
    assign error_code = queue_reg[rd_ptr_reg].err;

    assign hx = qsu_pkg::hex_decode(in_byte);

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        nres      = 3'd0;
        do_fail   = 1'b0;
        do_emit   = 1'b0;
        fail_err  = qsu_pkg::ERR_OK;
        cp        = acc_reg;
        for (int i = 0; i < qsu_pkg::MaxResults; i++)
        begin
            res[i] = qsu_pkg::make_result(8'd0, 1'b0, 1'b0, qsu_pkg::ERR_OK);
        end

        case (mode_reg)
            qsu_pkg::MODE_OPEN:
            begin
                if (in_byte != qsu_pkg::ChQuote || last_byte)
                begin
                    do_fail  = 1'b1;
                    fail_err = qsu_pkg::ERR_WRAPPER;
                end
                else
                begin
                    mode_next = qsu_pkg::MODE_BODY;
                end
            end
            qsu_pkg::MODE_BODY:
            begin
                if (last_byte)
                begin
                    if (in_byte != qsu_pkg::ChQuote)
                    begin
                        do_fail  = 1'b1;
                        fail_err = qsu_pkg::ERR_WRAPPER;
                    end
                    else
                    begin
                        mode_next = qsu_pkg::MODE_OPEN;
                        nres      = 3'd1;
                        res[0]    = qsu_pkg::make_result(8'd0, 1'b0, 1'b1, qsu_pkg::ERR_OK);
                    end
                end
                else if (in_byte == qsu_pkg::ChBslash)
                begin
                    mode_next = qsu_pkg::MODE_ESC;
                end
                else
                begin
                    nres   = 3'd1;
                    res[0] = qsu_pkg::make_result(in_byte, 1'b1, 1'b0, qsu_pkg::ERR_OK);
                end
            end
            qsu_pkg::MODE_ESC:
            begin
                if (last_byte)
                begin
                    do_fail  = 1'b1;
                    fail_err = qsu_pkg::ERR_ESCAPE;
                end
                else
                begin
                    mode_next = qsu_pkg::MODE_BODY;
                    nres      = 3'd1;
                    case (in_byte)
                        qsu_pkg::ChBslash, qsu_pkg::ChQuote, qsu_pkg::ChHash:
                            res[0] = qsu_pkg::make_result(in_byte, 1'b1, 1'b0,
                                                          qsu_pkg::ERR_OK);
                        qsu_pkg::ChN: res[0] = qsu_pkg::make_result(qsu_pkg::CtlLf, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChR: res[0] = qsu_pkg::make_result(qsu_pkg::CtlCr, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChT: res[0] = qsu_pkg::make_result(qsu_pkg::CtlTab, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChF: res[0] = qsu_pkg::make_result(qsu_pkg::CtlFf, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChV: res[0] = qsu_pkg::make_result(qsu_pkg::CtlVt, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChB: res[0] = qsu_pkg::make_result(qsu_pkg::CtlBs, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChA: res[0] = qsu_pkg::make_result(qsu_pkg::CtlBel, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChE: res[0] = qsu_pkg::make_result(qsu_pkg::CtlEsc, 1'b1,
                                                                    1'b0, qsu_pkg::ERR_OK);
                        qsu_pkg::ChU:
                        begin
                            nres      = 3'd0;
                            mode_next = qsu_pkg::MODE_USTART;
                            acc_next  = '0;
                            cnt_next  = '0;
                        end
                        qsu_pkg::ChX:
                        begin
                            nres      = 3'd0;
                            mode_next = qsu_pkg::MODE_HEX;
                            acc_next  = '0;
                            cnt_next  = '0;
                        end
                        default:
                        begin
                            nres   = 3'd2;
                            res[0] = qsu_pkg::make_result(qsu_pkg::ChBslash, 1'b1, 1'b0,
                                                          qsu_pkg::ERR_OK);
                            res[1] = qsu_pkg::make_result(in_byte, 1'b1, 1'b0,
                                                          qsu_pkg::ERR_OK);
                        end
                    endcase
                end
            end
            qsu_pkg::MODE_HEX:
            begin
                if (last_byte || !hx.ok)
                begin
                    do_fail  = 1'b1;
                    fail_err = qsu_pkg::ERR_HEX;
                end
                else if (cnt_reg != 3'd0)
                begin
                    mode_next = qsu_pkg::MODE_BODY;
                    acc_next  = '0;
                    cnt_next  = '0;
                    nres      = 3'd1;
                    res[0]    = qsu_pkg::make_result({acc_reg[3:0], hx.val}, 1'b1, 1'b0,
                                                     qsu_pkg::ERR_OK);
                end
                else
                begin
                    acc_next = {16'd0, acc_reg[3:0], hx.val};
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            qsu_pkg::MODE_USTART:
            begin
                if (last_byte || (in_byte != qsu_pkg::ChLbrace && !hx.ok))
                begin
                    do_fail  = 1'b1;
                    fail_err = qsu_pkg::ERR_UNICODE;
                end
                else if (in_byte == qsu_pkg::ChLbrace)
                begin
                    mode_next = qsu_pkg::MODE_UBRACE;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    mode_next = qsu_pkg::MODE_U4;
                    acc_next  = {20'd0, hx.val};
                    cnt_next  = 3'd1;
                end
            end
            qsu_pkg::MODE_U4:
            begin
                cp = {8'd0, acc_reg[11:0], hx.val};
                if (last_byte || !hx.ok)
                begin
                    do_fail  = 1'b1;
                    fail_err = qsu_pkg::ERR_UNICODE;
                end
                else if (cnt_reg >= 3'd3)
                begin
                    if ((cp & qsu_pkg::SurrMask) == qsu_pkg::SurrBase)
                    begin
                        do_fail  = 1'b1;
                        fail_err = qsu_pkg::ERR_SURROGATE;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
                else
                begin
                    acc_next = cp;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            qsu_pkg::MODE_UBRACE:
            begin
                if (last_byte)
                begin
                    do_fail  = 1'b1;
                    fail_err = qsu_pkg::ERR_UNTERMINATED;
                end
                else if (in_byte == qsu_pkg::ChRbrace)
                begin
                    if (cnt_reg == 3'd0)
                    begin
                        do_fail  = 1'b1;
                        fail_err = qsu_pkg::ERR_UNICODE;
                    end
                    else if (acc_reg > qsu_pkg::CpMax)
                    begin
                        do_fail  = 1'b1;
                        fail_err = qsu_pkg::ERR_TOO_LARGE;
                    end
                    else if ((acc_reg & qsu_pkg::SurrMask) == qsu_pkg::SurrBase)
                    begin
                        do_fail  = 1'b1;
                        fail_err = qsu_pkg::ERR_SURROGATE;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
                else if (!hx.ok || cnt_reg >= 3'd6)
                begin
                    do_fail  = 1'b1;
                    fail_err = qsu_pkg::ERR_UNICODE;
                end
                else
                begin
                    acc_next = {acc_reg[19:0], hx.val};
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            qsu_pkg::MODE_DRAIN:
            begin
                if (last_byte)
                begin
                    mode_next = qsu_pkg::MODE_OPEN;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
            end
            default:
            begin
                mode_next = qsu_pkg::MODE_OPEN;
                acc_next  = '0;
                cnt_next  = '0;
            end
        endcase

        if (do_fail)
        begin
            mode_next = last_byte ? qsu_pkg::MODE_OPEN : qsu_pkg::MODE_DRAIN;
            acc_next  = '0;
            cnt_next  = '0;
            nres      = 3'd1;
            res[0]    = qsu_pkg::make_result(8'd0, 1'b0, 1'b1, fail_err);
        end
        else if (do_emit)
        begin
            mode_next = qsu_pkg::MODE_BODY;
            acc_next  = '0;
            cnt_next  = '0;
            if (cp < 24'h80)
            begin
                nres   = 3'd1;
                res[0] = qsu_pkg::make_result(cp[7:0], 1'b1, 1'b0, qsu_pkg::ERR_OK);
            end
            else if (cp < 24'h800)
            begin
                nres   = 3'd2;
                res[0] = qsu_pkg::make_result({3'b110, cp[10:6]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
                res[1] = qsu_pkg::make_result({2'b10, cp[5:0]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
            end
            else if (cp < 24'h10000)
            begin
                nres   = 3'd3;
                res[0] = qsu_pkg::make_result({4'b1110, cp[15:12]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
                res[1] = qsu_pkg::make_result({2'b10, cp[11:6]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
                res[2] = qsu_pkg::make_result({2'b10, cp[5:0]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
            end
            else
            begin
                nres   = 3'd4;
                res[0] = qsu_pkg::make_result({5'b11110, cp[20:18]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
                res[1] = qsu_pkg::make_result({2'b10, cp[17:12]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
                res[2] = qsu_pkg::make_result({2'b10, cp[11:6]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
                res[3] = qsu_pkg::make_result({2'b10, cp[5:0]}, 1'b1, 1'b0,
                                              qsu_pkg::ERR_OK);
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push)
        begin
            fill_next = fill_next + (PtrW+1)'(nres);
        end
        if (pop)
        begin
            fill_next = fill_next - (PtrW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= qsu_pkg::MODE_OPEN;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                cnt_reg    <= cnt_next;
                wr_ptr_reg <= wr_ptr_reg + PtrW'(nres);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < qsu_pkg::MaxResults; i++)
            begin
                if (3'(i) < nres)
                begin
                    queue_reg[wr_ptr_reg + PtrW'(i)] <= res[i];
                end
            end
        end
    end

endmodule

// File: dv/quoted_string_unescaper_monitor.sv
// Monitor for the quoted string unescaper: predicts every result beat and checks the output side.
module quoted_string_unescaper_monitor
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       has_byte,
    input  logic       done_res,
    input  logic [2:0] error_code,
    output int         mismatch_count,
    output int         expected_left,
    output int         bytes_in,
    output int         beats_out,
    output int         strings_ok,
    output int         strings_bad
);
    timeunit 1ns;
    timeprecision 1ps;

    qsu_pkg::mode_t   parse_state;
    logic [23:0]      accum;
    logic [2:0]       ndigits;
    qsu_pkg::result_t decoded_q[$];
    qsu_pkg::result_t oldest;

    // {ok, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if (folded >= "a" && folded <= "f")
            return {1'b1, 4'(folded - 8'h57)};
        return 5'd0;
    endfunction

    function automatic void queue_byte(input logic [7:0] d);
        decoded_q.push_back('{data: d, has: 1'b1, done: 1'b0, err: qsu_pkg::ERR_OK});
    endfunction

    function automatic void queue_done(input qsu_pkg::err_t e);
        decoded_q.push_back('{data: 8'd0, has: 1'b0, done: 1'b1, err: e});
    endfunction

    function automatic void queue_fault(input qsu_pkg::err_t e, input logic at_last);
        parse_state = at_last ? qsu_pkg::MODE_OPEN : qsu_pkg::MODE_DRAIN;
        accum = '0;
        ndigits = '0;
        queue_done(e);
    endfunction

    function automatic void queue_utf8(input logic [23:0] cp);
        if (cp < 24'h80)
            queue_byte(cp[7:0]);
        else if (cp < 24'h800)
        begin
            queue_byte({3'b110, cp[10:6]});
            queue_byte({2'b10, cp[5:0]});
        end
        else if (cp < 24'h10000)
        begin
            queue_byte({4'b1110, cp[15:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
        end
        else
        begin
            queue_byte({5'b11110, cp[20:18]});
            queue_byte({2'b10, cp[17:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
        end
        parse_state = qsu_pkg::MODE_BODY;
        accum = '0;
        ndigits = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic at_last);
        logic [4:0] hx;
        hx = hex_nibble(b);
        case (parse_state)
            qsu_pkg::MODE_OPEN:
                if (b != qsu_pkg::ChQuote || at_last)
                    queue_fault(qsu_pkg::ERR_WRAPPER, at_last);
                else
                    parse_state = qsu_pkg::MODE_BODY;
            qsu_pkg::MODE_BODY:
                if (at_last)
                begin
                    if (b != qsu_pkg::ChQuote)
                        queue_fault(qsu_pkg::ERR_WRAPPER, 1'b1);
                    else
                    begin
                        parse_state = qsu_pkg::MODE_OPEN;
                        queue_done(qsu_pkg::ERR_OK);
                    end
                end
                else if (b == qsu_pkg::ChBslash)
                    parse_state = qsu_pkg::MODE_ESC;
                else
                    queue_byte(b);
            qsu_pkg::MODE_ESC:
                if (at_last)
                    queue_fault(qsu_pkg::ERR_ESCAPE, 1'b1);
                else
                begin
                    parse_state = qsu_pkg::MODE_BODY;
                    case (b)
                        qsu_pkg::ChBslash, qsu_pkg::ChQuote, qsu_pkg::ChHash: queue_byte(b);
                        qsu_pkg::ChN: queue_byte(qsu_pkg::CtlLf);
                        qsu_pkg::ChR: queue_byte(qsu_pkg::CtlCr);
                        qsu_pkg::ChT: queue_byte(qsu_pkg::CtlTab);
                        qsu_pkg::ChF: queue_byte(qsu_pkg::CtlFf);
                        qsu_pkg::ChV: queue_byte(qsu_pkg::CtlVt);
                        qsu_pkg::ChB: queue_byte(qsu_pkg::CtlBs);
                        qsu_pkg::ChA: queue_byte(qsu_pkg::CtlBel);
                        qsu_pkg::ChE: queue_byte(qsu_pkg::CtlEsc);
                        qsu_pkg::ChU:
                        begin
                            parse_state = qsu_pkg::MODE_USTART;
                            accum = '0;
                            ndigits = '0;
                        end
                        qsu_pkg::ChX:
                        begin
                            parse_state = qsu_pkg::MODE_HEX;
                            accum = '0;
                            ndigits = '0;
                        end
                        default:
                        begin
                            queue_byte(qsu_pkg::ChBslash);
                            queue_byte(b);
                        end
                    endcase
                end
            qsu_pkg::MODE_HEX:
                if (at_last || !hx[4])
                    queue_fault(qsu_pkg::ERR_HEX, at_last);
                else
                begin
                    accum = {16'd0, accum[3:0], hx[3:0]};
                    ndigits = ndigits + 3'd1;
                    if (ndigits >= 3'd2)
                    begin
                        queue_byte(accum[7:0]);
                        parse_state = qsu_pkg::MODE_BODY;
                        accum = '0;
                        ndigits = '0;
                    end
                end
            qsu_pkg::MODE_USTART:
                if (at_last)
                    queue_fault(qsu_pkg::ERR_UNICODE, 1'b1);
                else if (b == qsu_pkg::ChLbrace)
                begin
                    parse_state = qsu_pkg::MODE_UBRACE;
                    accum = '0;
                    ndigits = '0;
                end
                else if (!hx[4])
                    queue_fault(qsu_pkg::ERR_UNICODE, 1'b0);
                else
                begin
                    parse_state = qsu_pkg::MODE_U4;
                    accum = {20'd0, hx[3:0]};
                    ndigits = 3'd1;
                end
            qsu_pkg::MODE_U4:
                if (at_last || !hx[4])
                    queue_fault(qsu_pkg::ERR_UNICODE, at_last);
                else
                begin
                    accum = {8'd0, accum[11:0], hx[3:0]};
                    ndigits = ndigits + 3'd1;
                    if (ndigits >= 3'd4)
                    begin
                        if ((accum & qsu_pkg::SurrMask) == qsu_pkg::SurrBase)
                            queue_fault(qsu_pkg::ERR_SURROGATE, 1'b0);
                        else
                            queue_utf8(accum);
                    end
                end
            qsu_pkg::MODE_UBRACE:
                if (at_last)
                    queue_fault(qsu_pkg::ERR_UNTERMINATED, 1'b1);
                else if (b == qsu_pkg::ChRbrace)
                begin
                    if (ndigits == 3'd0)
                        queue_fault(qsu_pkg::ERR_UNICODE, 1'b0);
                    else if (accum > qsu_pkg::CpMax)
                        queue_fault(qsu_pkg::ERR_TOO_LARGE, 1'b0);
                    else if ((accum & qsu_pkg::SurrMask) == qsu_pkg::SurrBase)
                        queue_fault(qsu_pkg::ERR_SURROGATE, 1'b0);
                    else
                        queue_utf8(accum);
                end
                else if (!hx[4] || ndigits >= 3'd6)
                    queue_fault(qsu_pkg::ERR_UNICODE, 1'b0);
                else
                begin
                    accum = {accum[19:0], hx[3:0]};
                    ndigits = ndigits + 3'd1;
                end
            default:
                if (at_last)
                begin
                    parse_state = qsu_pkg::MODE_OPEN;
                    accum = '0;
                    ndigits = '0;
                end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state = qsu_pkg::MODE_OPEN;
            accum = '0;
            ndigits = '0;
            decoded_q.delete();
            mismatch_count = 0;
            expected_left = 0;
            bytes_in = 0;
            beats_out = 0;
            strings_ok = 0;
            strings_bad = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, last_byte);
                bytes_in++;
            end
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (done_res === 1'b1)
                begin
                    if (error_code == qsu_pkg::ERR_OK)
                        strings_ok++;
                    else
                        strings_bad++;
                end
                if (decoded_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected beat: got byte %02h has %0b done %0b code %0d",
                             $time, out_byte, has_byte, done_res, error_code);
                end
                else
                begin
                    oldest = decoded_q.pop_front();
                    if (out_byte !== oldest.data || has_byte !== oldest.has ||
                        done_res !== oldest.done || error_code !== oldest.err)
                    begin
                        mismatch_count++;
                        $display("%0t: mismatch: expected byte %02h has %0b done %0b code %0d",
                                 $time, oldest.data, oldest.has, oldest.done, oldest.err);
                        $display("%0t:           got      byte %02h has %0b done %0b code %0d",
                                 $time, out_byte, has_byte, done_res, error_code);
                    end
                end
            end
            expected_left = decoded_q.size();
        end
    end

endmodule

// File: dv/quoted_string_unescaper_unit_tb.sv
// Testbench top for the quoted string unescaper: stimulus, output back-pressure and verdict.
module quoted_string_unescaper_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       done_res;
    logic [2:0] error_code;

    int mismatch_count;
    int expected_left;
    int bytes_in;
    int beats_out;
    int strings_ok;
    int strings_bad;

    logic       in_fire = 1'b0;
    logic       hold_req;
    logic [8:0] beat_q[$];
    int         useful_beats;

    quoted_string_unescaper_unit dut (.*);

    quoted_string_unescaper_monitor monitor (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        in_fire <= in_valid && !in_stall;

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- generators

    function automatic void put_beat(input logic [7:0] b, input logic at_last);
        beat_q.push_back({at_last, b});
        useful_beats++;
    endfunction

    function automatic logic hex_like(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c >= "0" && c <= "9") || (folded >= "a" && folded <= "f");
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic void put_hex(input logic [23:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            put_beat(hex_char(4'(v >> (4 * i))), 1'b0);
    endfunction

    function automatic logic [7:0] pick_nonhex(input logic [7:0] excluded);
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (hex_like(c) || c == excluded);
        return c;
    endfunction

    function automatic logic [7:0] pick_nonquote();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == qsu_pkg::ChQuote)
            c = ~c;
        return c;
    endfunction

    function automatic logic [7:0] pick_simple_escape();
        case ($urandom_range(0, 10))
            0: return qsu_pkg::ChBslash;
            1: return qsu_pkg::ChQuote;
            2: return qsu_pkg::ChHash;
            3: return qsu_pkg::ChN;
            4: return qsu_pkg::ChR;
            5: return qsu_pkg::ChT;
            6: return qsu_pkg::ChF;
            7: return qsu_pkg::ChV;
            8: return qsu_pkg::ChB;
            9: return qsu_pkg::ChA;
            default: return qsu_pkg::ChE;
        endcase
    endfunction

    function automatic logic known_escape(input logic [7:0] c);
        case (c)
            qsu_pkg::ChBslash, qsu_pkg::ChQuote, qsu_pkg::ChHash, qsu_pkg::ChN,
            qsu_pkg::ChR, qsu_pkg::ChT, qsu_pkg::ChF, qsu_pkg::ChV, qsu_pkg::ChB,
            qsu_pkg::ChA, qsu_pkg::ChE, qsu_pkg::ChU, qsu_pkg::ChX:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic int digits_for(input logic [23:0] cp);
        int n;
        n = 1;
        while (n < 6 && (cp >> (4 * n)) != 0)
            n++;
        return n;
    endfunction

    // bytes that are dropped after an error, closed by the last byte
    function automatic void add_drain();
        repeat ($urandom_range(0, 3))
            beat_q.push_back({1'b0, 8'($urandom)});
        beat_q.push_back({1'b1, 8'($urandom)});
    endfunction

    function automatic void add_body_piece();
        logic [7:0]  c;
        logic [23:0] cp;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                c = 8'($urandom);
                if (c == qsu_pkg::ChBslash)
                    c = qsu_pkg::ChHash;
                put_beat(c, 1'b0);
            end
            3:
            begin
                put_beat(qsu_pkg::ChBslash, 1'b0);
                put_beat(pick_simple_escape(), 1'b0);
            end
            4:
            begin
                do
                    c = 8'($urandom);
                while (known_escape(c));
                put_beat(qsu_pkg::ChBslash, 1'b0);
                put_beat(c, 1'b0);
            end
            5:
            begin
                put_beat(qsu_pkg::ChBslash, 1'b0);
                put_beat(qsu_pkg::ChX, 1'b0);
                put_hex(24'($urandom), 2);
            end
            6, 7:
            begin
                case ($urandom_range(0, 2))
                    0: cp = 24'($urandom_range(0, 'h7F));
                    1: cp = 24'($urandom_range('h80, 'h7FF));
                    default: cp = 24'($urandom_range('h800, 'hFFFF));
                endcase
                if (cp[15:11] == 5'b11011)
                    cp[15] = 1'b0;
                put_beat(qsu_pkg::ChBslash, 1'b0);
                put_beat(qsu_pkg::ChU, 1'b0);
                put_hex(cp, 4);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: cp = 24'($urandom_range(0, 'h7F));
                    1: cp = 24'($urandom_range('h80, 'h7FF));
                    2: cp = 24'($urandom_range('h800, 'hFFFF));
                    default: cp = 24'($urandom_range('h10000, 'h10FFFF));
                endcase
                if (cp[23:11] == 13'h001B)
                    cp[15] = 1'b0;
                put_beat(qsu_pkg::ChBslash, 1'b0);
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(qsu_pkg::ChLbrace, 1'b0);
                put_hex(cp, $urandom_range(digits_for(cp), 6));
                put_beat(qsu_pkg::ChRbrace, 1'b0);
            end
        endcase
    endfunction

    // a malformed escape that ends the string
    function automatic void add_broken_tail();
        logic [23:0] cp;
        put_beat(qsu_pkg::ChBslash, 1'b0);
        case ($urandom_range(0, 14))
            0:
                put_beat(8'($urandom), 1'b1);
            1:
            begin
                put_beat(qsu_pkg::ChX, 1'b0);
                put_beat(8'($urandom), 1'b1);
            end
            2:
            begin
                put_beat(qsu_pkg::ChX, 1'b0);
                put_hex(24'($urandom), 1);
                put_beat(8'($urandom), 1'b1);
            end
            3:
            begin
                put_beat(qsu_pkg::ChX, 1'b0);
                put_beat(pick_nonhex(qsu_pkg::ChX), 1'b0);
                add_drain();
            end
            4:
            begin
                put_beat(qsu_pkg::ChX, 1'b0);
                put_hex(24'($urandom), 1);
                put_beat(pick_nonhex(qsu_pkg::ChX), 1'b0);
                add_drain();
            end
            5:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(8'($urandom), 1'b1);
            end
            6:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_hex(24'($urandom), $urandom_range(1, 3));
                put_beat(8'($urandom), 1'b1);
            end
            7:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(pick_nonhex(qsu_pkg::ChLbrace), 1'b0);
                add_drain();
            end
            8:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_hex(24'($urandom), $urandom_range(1, 3));
                put_beat(pick_nonhex(qsu_pkg::ChX), 1'b0);
                add_drain();
            end
            9:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(qsu_pkg::ChLbrace, 1'b0);
                put_hex(24'($urandom), $urandom_range(0, 6));
                put_beat(8'($urandom), 1'b1);
            end
            10:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(qsu_pkg::ChLbrace, 1'b0);
                put_beat(qsu_pkg::ChRbrace, 1'b0);
                add_drain();
            end
            11:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(qsu_pkg::ChLbrace, 1'b0);
                put_hex(24'($urandom), $urandom_range(1, 6));
                put_beat(pick_nonhex(qsu_pkg::ChRbrace), 1'b0);
                add_drain();
            end
            12:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(qsu_pkg::ChLbrace, 1'b0);
                put_hex(24'($urandom), 6);
                put_hex(24'($urandom), 1);
                add_drain();
            end
            13:
            begin
                put_beat(qsu_pkg::ChU, 1'b0);
                put_beat(qsu_pkg::ChLbrace, 1'b0);
                put_hex(24'($urandom_range('h110000, 'hFFFFFF)), 6);
                put_beat(qsu_pkg::ChRbrace, 1'b0);
                add_drain();
            end
            default:
            begin
                cp = 24'($urandom_range('hD800, 'hDFFF));
                put_beat(qsu_pkg::ChU, 1'b0);
                if ($urandom_range(0, 1))
                    put_hex(cp, 4);
                else
                begin
                    put_beat(qsu_pkg::ChLbrace, 1'b0);
                    put_hex(cp, $urandom_range(4, 6));
                    put_beat(qsu_pkg::ChRbrace, 1'b0);
                end
                add_drain();
            end
        endcase
    endfunction

    function automatic void add_string();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            put_beat(pick_nonquote(), 1'b0);
            add_drain();
        end
        else if (sel == 1)
            put_beat(pick_nonquote(), 1'b1);
        else if (sel == 2)
            put_beat(qsu_pkg::ChQuote, 1'b1);
        else
        begin
            put_beat(qsu_pkg::ChQuote, 1'b0);
            repeat ($urandom_range(0, 6))
                add_body_piece();
            sel = $urandom_range(0, 9);
            if (sel < 7)
                put_beat(qsu_pkg::ChQuote, 1'b1);
            else if (sel == 7)
                put_beat(pick_nonquote(), 1'b1);
            else
                add_broken_tail();
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // called at a falling edge; returns at the falling edge after the last beat is taken
    task automatic send_beats();
        int         burst;
        int         gap;
        logic [8:0] beat;
        burst = 0;
        while (beat_q.size() > 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            beat = beat_q.pop_front();
            in_valid <= 1'b1;
            in_byte <= beat[7:0];
            last_byte <= beat[8];
            @(negedge clk);
            while (!in_fire)
                @(negedge clk);
            burst--;
        end
    endtask

    initial
    begin : receiver
        int style;
        int run;
        int hold;
        logic hold_done;
        out_stall = 1'b0;
        hold = 0;
        hold_done = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            run = $urandom_range(20, 120);
            repeat (run)
            begin
                @(negedge clk);
                if (hold_req && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold = 300;
                end
                if (hold > 0)
                begin
                    hold--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    case (style)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'd0;
        last_byte = 1'b0;
        hold_req = 1'b0;
        useful_beats = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lone quote as last byte
        put_beat(qsu_pkg::ChQuote, 1'b1);
        // bad opening byte, then the drop run ends on the last byte
        put_beat(8'h00, 1'b0);
        put_beat(8'hFF, 1'b1);
        // extreme body bytes and the largest code point
        put_beat(qsu_pkg::ChQuote, 1'b0);
        put_beat(8'h00, 1'b0);
        put_beat(8'hFF, 1'b0);
        put_beat(qsu_pkg::ChBslash, 1'b0);
        put_beat(qsu_pkg::ChU, 1'b0);
        put_beat(qsu_pkg::ChLbrace, 1'b0);
        put_beat("1", 1'b0);
        put_beat("0", 1'b0);
        put_beat("F", 1'b0);
        put_beat("f", 1'b0);
        put_beat("F", 1'b0);
        put_beat("f", 1'b0);
        put_beat(qsu_pkg::ChRbrace, 1'b0);
        put_beat(qsu_pkg::ChQuote, 1'b1);
        // unknown escape, then a closing byte that is not a quote
        put_beat(qsu_pkg::ChQuote, 1'b0);
        put_beat(qsu_pkg::ChBslash, 1'b0);
        put_beat("z", 1'b0);
        put_beat("A", 1'b1);
        // empty string
        put_beat(qsu_pkg::ChQuote, 1'b0);
        put_beat(qsu_pkg::ChQuote, 1'b1);
        send_beats();

        hold_req <= 1'b1;
        useful_beats = 0;
        while (useful_beats < 360)
            add_string();
        send_beats();
        in_valid <= 1'b0;

        while (expected_left != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Streamed %0d bytes and checked %0d result beats.", bytes_in, beats_out);
        $display("Strings closed cleanly: %0d, strings ended by an error: %0d.",
                 strings_ok, strings_bad);
        if (mismatch_count == 0 && expected_left == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
